[hw/rtl/pgs_pkg.sv]
// ----------------------------------------------------------------------------
// Palette gradient spread package
// Shared widths, register indexes, reset values and the divider control type.
// ----------------------------------------------------------------------------
package pgs_pkg;

    // Color channel width and channel count (red, green, blue, alpha)
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;

    // Bit counter width for one serial division pass of CH_W steps
    localparam int BIT_W = $clog2(CH_W);

    // Default saturation of the spread count
    localparam int MAX_SPREAD_DEF = 64;

    // Configuration port
    localparam int              CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE = 2'd1;

    // Register reset values
    localparam logic [CH_W-1:0] IN_SIZE_RST  = 8'd16;
    localparam logic [CH_W-1:0] OUT_SIZE_RST = 8'd0;

    // Ceiling of the implied target size
    localparam logic [CH_W-1:0] TARGET_CAP = 8'd255;

    // Serial divider control
    typedef struct packed {
        logic load;   // capture dividend and divisor, clear remainder
        logic shift;  // one restoring step (one quotient bit)
    } div_ctl_t;

endpackage

[hw/rtl/pgs_serial_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Unsigned CH_W by CH_W division, one quotient bit per shift step.
// ----------------------------------------------------------------------------
module pgs_serial_div (
    input  logic                      clk,
    input  pgs_pkg::div_ctl_t         ctl,
    input  logic [pgs_pkg::CH_W-1:0]  dividend,
    input  logic [pgs_pkg::CH_W-1:0]  divisor,
    output logic [pgs_pkg::CH_W-1:0]  quotient,
    output logic [pgs_pkg::CH_W-1:0]  remainder
);
    import pgs_pkg::*;

    logic [CH_W-1:0] quo_reg;
    logic [CH_W-1:0] quo_next;
    logic [CH_W-1:0] rem_reg;
    logic [CH_W-1:0] rem_next;
    logic [CH_W-1:0] dsr_reg;
    logic [CH_W-1:0] dsr_next;
    logic [CH_W:0]   shifted;
    logic [CH_W:0]   trial;
    logic            fits;

    // One restoring step: bring down the next dividend bit, try the subtract
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[CH_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        fits     = (shifted >= {1'b0, dsr_reg});
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (ctl.load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (ctl.shift)
        begin
            quo_next = {quo_reg[CH_W-2:0], fits};
            rem_next = fits ? trial[CH_W-1:0] : shifted[CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/palette_gradient_spread_unit.sv]
// ----------------------------------------------------------------------------
// Palette gradient spread unit
// Expands a source palette by linear gradients between neighboring colors.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+---------------------
//  input    | in_valid, in_stall, first, red..alpha     | one source color
//  output   | out_valid, out_stall, red_out..alpha_out, | gradient colors
//           | last                                      |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// A color that is only stored or dropped is handled in the idle state; a
// pass-through color also passes the S_PASS state. A spreading color passes
// the count division (S_CDIV), S_CNT, the channel divisions (S_DDIV) and then
// emits count colors in S_EMIT. Reset clears the stored color and color count
// and loads in_size = 16, out_size = 0. out_stall holds the output register
// and freezes the gradient sequence; in_stall is high while busy.
// ----------------------------------------------------------------------------
module palette_gradient_spread_unit #(
    parameter int MAX_SPREAD = pgs_pkg::MAX_SPREAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // source colors
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          first,
    input  logic [pgs_pkg::CH_W-1:0]      red,
    input  logic [pgs_pkg::CH_W-1:0]      green,
    input  logic [pgs_pkg::CH_W-1:0]      blue,
    input  logic [pgs_pkg::CH_W-1:0]      alpha,
    // gradient colors
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pgs_pkg::CH_W-1:0]      red_out,
    output logic [pgs_pkg::CH_W-1:0]      green_out,
    output logic [pgs_pkg::CH_W-1:0]      blue_out,
    output logic [pgs_pkg::CH_W-1:0]      alpha_out,
    output logic                          last,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgs_pkg::CH_W-1:0]      cfg_data
);
    import pgs_pkg::*;

    localparam int CNT_W = $clog2(MAX_SPREAD + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_CDIV = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_DDIV = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [CH_W-1:0]                  in_size_reg, in_size_next;
    logic [CH_W-1:0]                  out_size_reg, out_size_next;
    logic [CH_W-1:0]                  seen_reg, seen_next;
    logic [NUM_CH-1:0][CH_W-1:0]      prev_reg, prev_next;
    logic [BIT_W-1:0]                 bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic                             out_valid_reg, out_valid_next;

    logic [NUM_CH-1:0][CH_W-1:0]      new_reg, new_next;
    logic [NUM_CH-1:0][CH_W-1:0]      mag_reg, mag_next;
    logic [NUM_CH-1:0]                neg_reg, neg_next;
    logic [NUM_CH-1:0][CH_W-1:0]      acc_q_reg, acc_q_next;
    logic [NUM_CH-1:0][CNT_W-1:0]     acc_r_reg, acc_r_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [NUM_CH-1:0][CH_W-1:0]      out_color_reg, out_color_next;
    logic                             out_last_reg, out_last_next;

    logic [NUM_CH-1:0][CH_W-1:0]      in_color;
    logic [NUM_CH-1:0][CH_W-1:0]      div_dividend;
    logic [NUM_CH-1:0][CH_W-1:0]      div_divisor;
    logic [NUM_CH-1:0][CH_W-1:0]      div_quo;
    logic [NUM_CH-1:0][CH_W-1:0]      div_rem;
    div_ctl_t                         div_ctl;

    logic                             in_accept;
    logic                             slot_free;
    logic [CH_W+1:0]                  in_size_x4;
    logic [CH_W-1:0]                  target;
    logic                             pass_mode;
    logic [CNT_W-1:0]                 count_calc;
    logic [CNT_W-1:0]                 den;
    logic                             last_idx;
    logic [NUM_CH-1:0][CNT_W:0]       r_sum;
    logic [NUM_CH-1:0][CH_W-1:0]      emit_color;

    assign in_color  = {alpha, blue, green, red};
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Effective target size and pass-through decision
    always_comb
    begin
        in_size_x4 = {in_size_reg, 2'b00};
        if (out_size_reg != '0)
            target = out_size_reg;
        else if (in_size_x4 > {2'b00, TARGET_CAP})
            target = TARGET_CAP;
        else
            target = in_size_x4[CH_W-1:0];
        pass_mode = (in_size_reg == '0) || (target <= in_size_reg);
    end

    // Spread count from the lane 0 quotient, saturated at MAX_SPREAD, at least 1
    always_comb
    begin
        if (div_quo[0] > CH_W'(MAX_SPREAD))
            count_calc = CNT_W'(MAX_SPREAD);
        else if (div_quo[0] == '0)
            count_calc = CNT_W'(1);
        else
            count_calc = div_quo[0][CNT_W-1:0];
        if (state_reg == S_CNT)
            den = count_calc - CNT_W'(1);
        else
            den = count_reg - CNT_W'(1);
        last_idx = (idx_reg == den);
    end

    // Divider operands: count division on accept, channel steps afterwards
    always_comb
    begin
        div_ctl.load  = (state_reg == S_CNT) ||
                        (in_accept && !pass_mode && !(first || seen_reg == '0) &&
                         (seen_reg < in_size_reg));
        div_ctl.shift = (state_reg == S_CDIV) || (state_reg == S_DDIV);
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (state_reg == S_IDLE)
            begin
                div_dividend[c] = target;
                div_divisor[c]  = in_size_reg;
            end
            else
            begin
                div_dividend[c] = mag_reg[c];
                div_divisor[c]  = CH_W'(den);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CH; g++)
        begin : g_lane
            pgs_serial_div u_div (
                .clk       (clk),
                .ctl       (div_ctl),
                .dividend  (div_dividend[g]),
                .divisor   (div_divisor[g]),
                .quotient  (div_quo[g]),
                .remainder (div_rem[g])
            );
        end
    endgenerate

    // Current gradient color and next quotient/remainder step per channel
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            emit_color[c] = neg_reg[c] ? (prev_reg[c] - acc_q_reg[c])
                                       : (prev_reg[c] + acc_q_reg[c]);
            r_sum[c]      = {1'b0, acc_r_reg[c]} + {1'b0, div_rem[c][CNT_W-1:0]};
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        in_size_next   = in_size_reg;
        out_size_next  = out_size_reg;
        seen_next      = seen_reg;
        prev_next      = prev_reg;
        bit_cnt_next   = bit_cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        new_next       = new_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_q_next     = acc_q_reg;
        acc_r_next     = acc_r_reg;
        count_next     = count_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IN_SIZE:  in_size_next  = cfg_data;
                REG_OUT_SIZE: out_size_next = cfg_data;
                default:      ;
            endcase
        end

        // output register drains on a taken transaction
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    new_next = in_color;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        neg_next[c] = (in_color[c] < prev_reg[c]);
                        mag_next[c] = neg_next[c] ? (prev_reg[c] - in_color[c])
                                                  : (in_color[c] - prev_reg[c]);
                    end
                    if (pass_mode)
                        state_next = S_PASS;
                    else if (first || seen_reg == '0)
                    begin
                        prev_next = in_color;
                        seen_next = CH_W'(1);
                    end
                    else if (seen_reg < in_size_reg)
                    begin
                        bit_cnt_next = '0;
                        state_next   = S_CDIV;
                    end
                end
            end
            S_PASS:
            begin
                if (slot_free)
                begin
                    out_color_next = new_reg;
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CDIV:
            begin
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(CH_W - 1))
                    state_next = S_CNT;
            end
            S_CNT:
            begin
                count_next   = count_calc;
                bit_cnt_next = '0;
                idx_next     = '0;
                acc_q_next   = '0;
                acc_r_next   = '0;
                state_next   = S_DDIV;
            end
            S_DDIV:
            begin
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(CH_W - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_color_next = emit_color;
                    out_last_next  = last_idx;
                    out_valid_next = 1'b1;
                    if (last_idx)
                    begin
                        prev_next  = new_reg;
                        seen_next  = seen_reg + CH_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                        // q += |d| / den, carry the remainder
                        for (int c = 0; c < NUM_CH; c++)
                        begin
                            if (r_sum[c] >= {1'b0, den})
                            begin
                                acc_r_next[c] = CNT_W'(r_sum[c] - {1'b0, den});
                                acc_q_next[c] = acc_q_reg[c] + div_quo[c] + CH_W'(1);
                            end
                            else
                            begin
                                acc_r_next[c] = r_sum[c][CNT_W-1:0];
                                acc_q_next[c] = acc_q_reg[c] + div_quo[c];
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_size_reg   <= IN_SIZE_RST;
            out_size_reg  <= OUT_SIZE_RST;
            seen_reg      <= '0;
            prev_reg      <= '0;
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_size_reg   <= in_size_next;
            out_size_reg  <= out_size_next;
            seen_reg      <= seen_next;
            prev_reg      <= prev_next;
            bit_cnt_reg   <= bit_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        new_reg       <= new_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        acc_q_reg     <= acc_q_next;
        acc_r_reg     <= acc_r_next;
        count_reg     <= count_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_color_reg[0];
    assign green_out = out_color_reg[1];
    assign blue_out  = out_color_reg[2];
    assign alpha_out = out_color_reg[3];
    assign last      = out_last_reg;

    // Gradient index never runs past the spread count
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg < count_reg))
        else $error("gradient index beyond spread count");

    // Spread count is saturated and nonzero once computed
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DDIV) |->
        ((count_reg != '0) && (count_reg <= CNT_W'(MAX_SPREAD))))
        else $error("spread count out of range");

    // A run of two or more colors ends exactly on the new source color
    a_run_ends_on_new: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && last_idx && count_reg != CNT_W'(1)) |=>
        (out_color_reg == $past(new_reg) && out_last_reg))
        else $error("gradient run does not end on the new color");

endmodule
